### design/rwcp_pkg.sv
package rwcp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_SIZE = 32'd14;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF   = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE   = 3'd2;
  localparam logic [2:0] ST_FMT_SHORT  = 3'd3;
  localparam logic [2:0] ST_RIFF_END   = 3'd4;
  localparam logic [2:0] ST_EARLY_END  = 3'd5;

  localparam int unsigned OUT_DATA_W = 104;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] format_offset;
    logic        format_found;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic        data_found;
  } res_t;

endpackage

### design/rwcp_core.sv
module rwcp_core #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  input  logic           first_i,
  input  logic           last_i,
  input  logic           want_format_i,
  output logic           res_valid_o,
  output rwcp_pkg::res_t res_o
);
  import rwcp_pkg::*;

  localparam logic PH_HEADER = 1'b0;
  localparam logic PH_WALK   = 1'b1;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  logic [31:0]            wa_q, wa_c, wa_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_c, pos_d;
  logic                   ph_q, ph_c, ph_d;
  logic [31:0]            tag_q, tag_c, tag_d;
  logic [31:0]            size_q, size_c, size_d;
  logic [32:0]            rend_q, rend_c, rend_d;
  logic [32:0]            ncs_q, ncs_c, ncs_d;
  logic                   fseen_q, fseen_c, fseen_d;
  logic [31:0]            fpos_q, fpos_c, fpos_d;
  logic                   dseen_q, dseen_c, dseen_d;
  logic [31:0]            dpos_q, dpos_c, dpos_d;
  logic [31:0]            dlen_q, dlen_c, dlen_d;
  logic                   fin_q, fin_c, fin_d;

  logic                   clr;
  logic [33:0]            pos_w;
  logic [33:0]            tag_at;
  logic [33:0]            size_at;
  logic [32:0]            body;
  logic [31:0]            pad;
  logic                   decided;
  logic [2:0]             status;

  assign clr = step_i && first_i;

  always_comb begin
    wa_c    = clr ? '0 : wa_q;
    pos_c   = clr ? '0 : pos_q;
    ph_c    = clr ? PH_HEADER : ph_q;
    tag_c   = clr ? '0 : tag_q;
    size_c  = clr ? '0 : size_q;
    rend_c  = clr ? '0 : rend_q;
    ncs_c   = clr ? '0 : ncs_q;
    fseen_c = clr ? 1'b0 : fseen_q;
    fpos_c  = clr ? '0 : fpos_q;
    dseen_c = clr ? 1'b0 : dseen_q;
    dpos_c  = clr ? '0 : dpos_q;
    dlen_c  = clr ? '0 : dlen_q;
    fin_c   = clr ? 1'b0 : fin_q;
  end

  assign pos_w   = 34'(pos_c);
  assign tag_at  = {1'b0, ncs_c} + 34'd3;
  assign size_at = {1'b0, ncs_c} + 34'd7;
  assign body    = ncs_c + 33'd8;
  assign pad     = ({byte_i, wa_c[31:8]} + 32'd1) & ~32'd1;

  always_comb begin
    wa_d    = wa_c;
    pos_d   = pos_c;
    ph_d    = ph_c;
    tag_d   = tag_c;
    size_d  = size_c;
    rend_d  = rend_c;
    ncs_d   = ncs_c;
    fseen_d = fseen_c;
    fpos_d  = fpos_c;
    dseen_d = dseen_c;
    dpos_d  = dpos_c;
    dlen_d  = dlen_c;
    fin_d   = fin_c;
    decided = 1'b0;
    status  = ST_OK;
    if (step_i && !fin_c) begin
      wa_d = {byte_i, wa_c[31:8]};
      if (ph_c == PH_HEADER) begin
        if (pos_c == OFFSET_BITS'(3)) begin
          if (wa_d != TAG_RIFF) begin
            decided = 1'b1;
            status  = ST_NOT_RIFF;
          end
        end else if (pos_c == OFFSET_BITS'(7)) begin
          rend_d = {1'b0, wa_d} + 33'd8;
        end else if (pos_c == OFFSET_BITS'(11)) begin
          if (wa_d != TAG_WAVE) begin
            decided = 1'b1;
            status  = ST_NOT_WAVE;
          end else begin
            ncs_d = 33'd12;
            ph_d  = PH_WALK;
            if (!(33'd12 < rend_c)) begin
              decided = 1'b1;
              status  = ST_RIFF_END;
            end
          end
        end
      end else if (pos_w == tag_at) begin
        tag_d = wa_d;
      end else if (pos_w == size_at) begin
        size_d = wa_d;
        if (tag_c == TAG_FMT && want_format_i && !fseen_c) begin
          if (wa_d < FMT_MIN_SIZE) begin
            decided = 1'b1;
            status  = ST_FMT_SHORT;
          end else begin
            fseen_d = 1'b1;
            fpos_d  = body[31:0];
            if (dseen_c && dlen_c != 32'd0) begin
              decided = 1'b1;
              status  = ST_OK;
            end
          end
        end else if (tag_c == TAG_DATA && (!dseen_c || dlen_c == 32'd0)) begin
          dseen_d = 1'b1;
          dpos_d  = body[31:0];
          dlen_d  = wa_d;
          if (!want_format_i || fseen_c) begin
            decided = 1'b1;
            status  = ST_OK;
          end
        end
        if (!decided) begin
          ncs_d = body + {1'b0, pad};
          if (!(ncs_d < rend_c)) begin
            decided = 1'b1;
            status  = ST_RIFF_END;
          end
        end
      end
      pos_d = (pos_c == POS_MAX) ? pos_c : pos_c + OFFSET_BITS'(1);
      if (!decided && last_i) begin
        decided = 1'b1;
        status  = ST_EARLY_END;
      end
      if (decided) begin
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q    <= '0;
      pos_q   <= '0;
      ph_q    <= PH_HEADER;
      tag_q   <= '0;
      size_q  <= '0;
      rend_q  <= '0;
      ncs_q   <= '0;
      fseen_q <= 1'b0;
      fpos_q  <= '0;
      dseen_q <= 1'b0;
      dpos_q  <= '0;
      dlen_q  <= '0;
      fin_q   <= 1'b0;
    end else begin
      wa_q    <= wa_d;
      pos_q   <= pos_d;
      ph_q    <= ph_d;
      tag_q   <= tag_d;
      size_q  <= size_d;
      rend_q  <= rend_d;
      ncs_q   <= ncs_d;
      fseen_q <= fseen_d;
      fpos_q  <= fpos_d;
      dseen_q <= dseen_d;
      dpos_q  <= dpos_d;
      dlen_q  <= dlen_d;
      fin_q   <= fin_d;
    end
  end

  assign res_valid_o          = decided;
  assign res_o.status         = status;
  assign res_o.format_offset  = fseen_d ? fpos_d : 32'd0;
  assign res_o.format_found   = fseen_d;
  assign res_o.data_offset    = dseen_d ? dpos_d : 32'd0;
  assign res_o.data_size      = dseen_d ? dlen_d : 32'd0;
  assign res_o.data_found     = dseen_d;

endmodule

### design/riff_wave_chunk_parser_unit.sv
// path: an accepted byte waits in the input register, and its result, if any, goes into the result register
// throughput: one byte per cycle while the result register is empty or being read, set by
//   the single-pass step between the input register and the result register
// reset: asynchronous, clears all parse state as if a file starts, sets
//   want_format to 1 and empties both the input and the result register
module riff_wave_chunk_parser_unit #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // data_byte
  input  logic         s_axis_tuser_i,  // first_byte
  input  logic         s_axis_tlast_i,  // last_byte
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status, format_offset, format_found, data_offset, data_size, data_found, zero pad
  output logic [rwcp_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import rwcp_pkg::*;

  logic                  want_q;
  logic                  in_valid_q;
  logic [7:0]            in_byte_q;
  logic                  in_first_q;
  logic                  in_last_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  advance;
  logic                  res_valid;
  res_t                  res;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_q <= 1'b1;
    end else if (cfg_we_i) begin
      want_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i;
      in_last_q  <= s_axis_tlast_i;
    end
  end

  rwcp_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte_q),
    .first_i       (in_first_q),
    .last_i        (in_last_q),
    .want_format_i (want_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  assign out_data_d = {3'b000, res.data_found, res.data_size, res.data_offset,
                       res.format_found, res.format_offset, res.status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

### design/rwcp_checker.sv
module rwcp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [rwcp_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import rwcp_pkg::*;

  logic [2:0] status;
  logic       format_found;
  logic       data_found;

  assign status       = m_axis_tdata_o[2:0];
  assign format_found = m_axis_tdata_o[35];
  assign data_found   = m_axis_tdata_o[100];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> status <= ST_EARLY_END)
    else $error("status code out of range");

  a_ok_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status == ST_OK |-> data_found)
    else $error("success without data chunk");

  a_short_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status == ST_FMT_SHORT |-> !format_found)
    else $error("short fmt reported with fmt recorded");

  a_early_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (status == ST_NOT_RIFF || status == ST_NOT_WAVE)
      |-> !format_found && !data_found)
    else $error("header failure with chunks recorded");

endmodule

bind riff_wave_chunk_parser_unit rwcp_checker u_rwcp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

### tb/sv/tb_riff_wave_chunk_parser_unit.sv
`timescale 1ns / 100ps

module tb_riff_wave_chunk_parser_unit;
  import rwcp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned LONG_STALL = 300;

  typedef enum logic {PH_HEADER, PH_WALK} parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       chk;
    logic [2:0] status;
  } wav_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_wdata = 1'b0;
  logic         s_vld = 1'b0;
  logic [7:0]   s_data = 8'h00;
  logic         s_first = 1'b0;
  logic         s_last = 1'b0;
  logic         s_rdy;
  logic         m_vld;
  logic         m_rdy = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;

  // predictor state
  logic         want_fmt;
  logic [31:0]  word_acc;
  logic [31:0]  byte_pos;
  parse_phase_e phase;
  logic [31:0]  chunk_tag;
  logic [31:0]  chunk_size;
  logic [32:0]  riff_end;
  logic [32:0]  next_start;
  logic         fmt_seen;
  logic [31:0]  fmt_pos;
  logic         data_seen;
  logic [31:0]  data_pos;
  logic [31:0]  data_len;
  logic         done;

  res_t         verdict_q[$];
  wav_row_t     dir_tab[$];
  logic [7:0]   wav_q[$];
  int unsigned  parsed_cnt = 0;
  int unsigned  verdict_cnt = 0;
  int unsigned  err_cnt = 0;
  int unsigned  cyc_cnt = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  stall_req = 0;
  int unsigned  stall_ack = 0;
  int unsigned  stall_left = 0;

  riff_wave_chunk_parser_unit #(
    .OFFSET_BITS(32)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_vld),
    .s_axis_tready_o(s_rdy),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_first),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_vld),
    .m_axis_tready_i(m_rdy),
    .m_axis_tdata_o (m_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void clear_parse();
    word_acc = '0;
    byte_pos = '0;
    phase = PH_HEADER;
    chunk_tag = '0;
    chunk_size = '0;
    riff_end = '0;
    next_start = '0;
    fmt_seen = 1'b0;
    fmt_pos = '0;
    data_seen = 1'b0;
    data_pos = '0;
    data_len = '0;
    done = 1'b0;
  endfunction

  function automatic logic parse_wav_byte(input logic [7:0] b, input logic f, input logic l,
                                          output res_t r);
    logic [31:0] idx;
    logic [32:0] k;
    logic [32:0] body;
    logic [31:0] pad;
    logic [2:0]  st;
    logic        hit;
    r = '0;
    hit = 1'b0;
    st = ST_OK;
    if (f) clear_parse();
    if (done) return 1'b0;
    idx = byte_pos;
    word_acc = {b, word_acc[31:8]};
    if (phase == PH_HEADER) begin
      if (idx == 32'd3) begin
        if (word_acc != TAG_RIFF) begin
          hit = 1'b1;
          st = ST_NOT_RIFF;
        end
      end else if (idx == 32'd7) begin
        riff_end = 33'd8 + {1'b0, word_acc};
      end else if (idx == 32'd11) begin
        if (word_acc != TAG_WAVE) begin
          hit = 1'b1;
          st = ST_NOT_WAVE;
        end else begin
          next_start = 33'd12;
          phase = PH_WALK;
          if (!(next_start < riff_end)) begin
            hit = 1'b1;
            st = ST_RIFF_END;
          end
        end
      end
    end else if ({1'b0, idx} >= next_start) begin
      k = {1'b0, idx} - next_start;
      if (k == 33'd3) begin
        chunk_tag = word_acc;
      end else if (k == 33'd7) begin
        chunk_size = word_acc;
        body = next_start + 33'd8;
        pad = (chunk_size + 32'd1) & ~32'd1;
        if (chunk_tag == TAG_FMT && want_fmt && !fmt_seen) begin
          if (chunk_size < FMT_MIN_SIZE) begin
            hit = 1'b1;
            st = ST_FMT_SHORT;
          end else begin
            fmt_seen = 1'b1;
            fmt_pos = body[31:0];
            if (data_seen && data_len != 32'd0) hit = 1'b1;
          end
        end else if (chunk_tag == TAG_DATA && (!data_seen || data_len == 32'd0)) begin
          data_seen = 1'b1;
          data_pos = body[31:0];
          data_len = chunk_size;
          if (!want_fmt || fmt_seen) hit = 1'b1;
        end
        if (!hit) begin
          next_start = body + {1'b0, pad};
          if (!(next_start < riff_end)) begin
            hit = 1'b1;
            st = ST_RIFF_END;
          end
        end
      end
    end
    if (idx != 32'hFFFF_FFFF) byte_pos = idx + 32'd1;
    if (!hit && l) begin
      hit = 1'b1;
      st = ST_EARLY_END;
    end
    if (!hit) return 1'b0;
    done = 1'b1;
    r.status = st;
    r.format_offset = fmt_seen ? fmt_pos : 32'd0;
    r.format_found = fmt_seen;
    r.data_offset = data_seen ? data_pos : 32'd0;
    r.data_size = data_seen ? data_len : 32'd0;
    r.data_found = data_seen;
    return 1'b1;
  endfunction

  // receiver side: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (stall_ack != stall_req) begin
      stall_ack <= stall_req;
      stall_left <= LONG_STALL;
      m_rdy <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_rdy <= 1'b0;
    end else begin
      m_rdy <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    res_t act;
    res_t want;
    if (m_vld && m_rdy) begin
      act.status = m_data[2:0];
      act.format_offset = m_data[34:3];
      act.format_found = m_data[35];
      act.data_offset = m_data[67:36];
      act.data_size = m_data[99:68];
      act.data_found = m_data[100];
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, act);
        err_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (act.status != want.status) begin
          $display("%0t status exp %0d act %0d", $time, want.status, act.status);
          err_cnt++;
        end
        if (act.format_offset != want.format_offset) begin
          $display("%0t format_offset exp %h act %h", $time, want.format_offset,
                   act.format_offset);
          err_cnt++;
        end
        if (act.format_found != want.format_found) begin
          $display("%0t format_found exp %0d act %0d", $time, want.format_found,
                   act.format_found);
          err_cnt++;
        end
        if (act.data_offset != want.data_offset) begin
          $display("%0t data_offset exp %h act %h", $time, want.data_offset, act.data_offset);
          err_cnt++;
        end
        if (act.data_size != want.data_size) begin
          $display("%0t data_size exp %h act %h", $time, want.data_size, act.data_size);
          err_cnt++;
        end
        if (act.data_found != want.data_found) begin
          $display("%0t data_found exp %0d act %0d", $time, want.data_found, act.data_found);
          err_cnt++;
        end
      end
    end
  end

  function automatic wav_row_t row(input logic [7:0] b, input logic f, input logic l,
                                   input logic chk, input logic [2:0] st);
    wav_row_t t;
    t.data = b;
    t.first = f;
    t.last = l;
    t.chk = chk;
    t.status = st;
    return t;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic f, input logic l,
                           input logic chk, input logic [2:0] st);
    res_t r;
    logic hit;
    while ($urandom_range(99) < send_idle_pct) begin
      s_vld <= 1'b0;
      @(posedge clk_i);
    end
    s_vld <= 1'b1;
    s_data <= b;
    s_first <= f;
    s_last <= l;
    do @(posedge clk_i); while (!s_rdy);
    parsed_cnt++;
    hit = parse_wav_byte(b, f, l, r);
    if (chk) begin
      r = '0;
      r.status = st;
      hit = 1'b1;
    end
    if (hit) begin
      verdict_q.push_back(r);
      verdict_cnt++;
    end
  endtask

  task automatic drain_requests();
    s_vld <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic void put32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) wav_q.push_back(w[8*i +: 8]);
  endfunction

  function automatic void build_wav_file();
    logic [31:0] tag;
    logic [31:0] sz;
    logic [31:0] len;
    int unsigned c;
    int unsigned n;
    wav_q.delete();
    if ($urandom_range(99) < 8) begin
      n = $urandom_range(1, 8);
      repeat (n) wav_q.push_back(8'($urandom));
      return;
    end
    put32(TAG_RIFF);
    put32(32'd0);
    put32(TAG_WAVE);
    n = $urandom_range(0, 4);
    repeat (n) begin
      c = $urandom_range(99);
      if (c < 35) begin
        tag = TAG_FMT;
        sz = ($urandom_range(99) < 15) ? $urandom_range(13) : $urandom_range(14, 20);
      end else if (c < 70) begin
        tag = TAG_DATA;
        sz = ($urandom_range(99) < 25) ? 32'd0 : $urandom_range(1, 12);
      end else if (c < 88) begin
        tag = $urandom;
        sz = $urandom_range(9);
      end else begin
        tag = ($urandom_range(1) ? TAG_FMT : TAG_DATA) ^ (32'd1 << $urandom_range(31));
        sz = $urandom_range(9);
      end
      if ($urandom_range(99) < 4) begin
        case ($urandom_range(2))
          0: sz = 32'hFFFF_FFFF;
          1: sz = 32'hFFFF_FFFE;
          default: sz = $urandom;
        endcase
      end
      put32(tag);
      put32(sz);
      if (sz < 32'd64) repeat ((sz + 32'd1) & ~32'd1) wav_q.push_back(8'($urandom));
    end
    len = wav_q.size() - 8;
    c = $urandom_range(99);
    if (c < 6) len = $urandom_range(0, 16);
    else if (c < 10) len = $urandom_range(1) ? 32'hFFFF_FFFF : 32'hFFFF_FFF4;
    else if (c < 14) len = $urandom;
    for (int i = 0; i < 4; i++) wav_q[4 + i] = len[8*i +: 8];
    if ($urandom_range(99) < 5) wav_q[$urandom_range(0, 3)] ^= 8'd1 << $urandom_range(7);
    if ($urandom_range(99) < 5) wav_q[$urandom_range(8, 11)] ^= 8'd1 << $urandom_range(7);
  endfunction

  task automatic send_wav_file();
    int unsigned last_idx;
    int unsigned m;
    logic use_first;
    logic use_last;
    use_first = ($urandom_range(99) >= 3);
    m = $urandom_range(99);
    last_idx = wav_q.size() - 1;
    use_last = 1'b1;
    if (m >= 85) use_last = 1'b0;
    else if (m >= 70) last_idx = $urandom_range(0, wav_q.size() - 1);
    for (int unsigned i = 0; i <= last_idx; i++) begin
      push_byte(wav_q[i], (i == 0) && use_first, (i == last_idx) && use_last, 1'b0, ST_OK);
    end
  endtask

  initial begin
    logic wf;
    want_fmt = 1'b1;
    clear_parse();

    // no first byte after reset, then header verdicts and early end of file
    dir_tab.push_back(row(8'h52, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h49, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h46, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'hFF, 1'b0, 1'b0, 1'b1, ST_NOT_RIFF));
    dir_tab.push_back(row(8'h52, 1'b1, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h49, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h46, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h46, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h04, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h57, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h41, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h56, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h45, 1'b0, 1'b0, 1'b1, ST_RIFF_END));
    dir_tab.push_back(row(8'h00, 1'b1, 1'b1, 1'b1, ST_EARLY_END));
    dir_tab.push_back(row(8'h52, 1'b1, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h49, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h46, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'h46, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'hFF, 1'b0, 1'b0, 1'b0, ST_OK));
    dir_tab.push_back(row(8'hFF, 1'b0, 1'b1, 1'b1, ST_EARLY_END));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      push_byte(dir_tab[i].data, dir_tab[i].first, dir_tab[i].last, dir_tab[i].chk,
                dir_tab[i].status);
    end

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      drain_requests();
      wf = (ph < 4) ? ph[0] : 1'($urandom_range(1));
      cfg_we <= 1'b1;
      cfg_wdata <= wf;
      @(posedge clk_i);
      cfg_we <= 1'b0;
      want_fmt = wf;
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 49;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 49;
        end
        default: begin
          send_idle_pct = 33;
          recv_stall_pct <= 33;
        end
      endcase
      if (ph == 2) begin
        // hold the result side while short failing files keep coming
        stall_req <= stall_req + 1;
        repeat (12) begin
          wav_q.delete();
          repeat (4) wav_q.push_back(8'($urandom));
          for (int unsigned i = 0; i < 4; i++) push_byte(wav_q[i], i == 0, 1'b0, 1'b0, ST_OK);
        end
      end
      while (parsed_cnt < (ph + 1) * ITEM_TARGET / NUM_PHASES ||
             (ph == NUM_PHASES - 1 && verdict_cnt < 48)) begin
        build_wav_file();
        send_wav_file();
      end
    end

    drain_requests();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
